@@ hw/rtl/rkd_pkg.sv @@
// ----------------------------------------------------------------------------
// rkd_pkg
// Types and constants shared by the RK number decoder pipeline.
// ----------------------------------------------------------------------------
package rkd_pkg;

	// ceil(2^35 / 25): floor(n * RECIP25 >> 35) is exact for any 30-bit n
	localparam logic [30:0] RECIP25   = 31'd1374389535;
	localparam int          RECIP_SH  = 35;
	localparam logic [4:0]  DIV25     = 5'd25;

	// float form: exponent bias adjust for a 21-bit significand with hidden bit
	localparam logic signed [11:0] NORM_EOFS = 12'sd1043;
	localparam logic signed [11:0] SUB_E     = -12'sd1042;
	localparam logic [10:0]        EXP_ALL1  = 11'h7ff;
	localparam logic [10:0]        INT_EBASE = 11'd1052;   // bias + 29

	// floor(r * 2^32 / 25) for remainders 0..24
	localparam logic [31:0] FRAC_TAB [0:31] = '{
		32'((64'd4294967296 *  0) / 25), 32'((64'd4294967296 *  1) / 25),
		32'((64'd4294967296 *  2) / 25), 32'((64'd4294967296 *  3) / 25),
		32'((64'd4294967296 *  4) / 25), 32'((64'd4294967296 *  5) / 25),
		32'((64'd4294967296 *  6) / 25), 32'((64'd4294967296 *  7) / 25),
		32'((64'd4294967296 *  8) / 25), 32'((64'd4294967296 *  9) / 25),
		32'((64'd4294967296 * 10) / 25), 32'((64'd4294967296 * 11) / 25),
		32'((64'd4294967296 * 12) / 25), 32'((64'd4294967296 * 13) / 25),
		32'((64'd4294967296 * 14) / 25), 32'((64'd4294967296 * 15) / 25),
		32'((64'd4294967296 * 16) / 25), 32'((64'd4294967296 * 17) / 25),
		32'((64'd4294967296 * 18) / 25), 32'((64'd4294967296 * 19) / 25),
		32'((64'd4294967296 * 20) / 25), 32'((64'd4294967296 * 21) / 25),
		32'((64'd4294967296 * 22) / 25), 32'((64'd4294967296 * 23) / 25),
		32'((64'd4294967296 * 24) / 25), 32'd0, 32'd0, 32'd0,
		32'd0, 32'd0, 32'd0, 32'd0
	};

	typedef struct packed {
		logic                sign;
		logic [29:0]         n;        // normalised significand, bit 29 set
		logic signed [11:0]  e;        // value = n * 2^e
		logic                direct;   // result fully known already
		logic [63:0]         direct_bits;
		logic                was_integer;
		logic                was_scaled;
	} unp_t;

	typedef struct packed {
		logic                sign;
		logic [25:0]         q0;       // n / 25
		logic [4:0]          r;        // n % 25
		logic signed [11:0]  e;
		logic                direct;
		logic [63:0]         direct_bits;
		logic                was_integer;
		logic                was_scaled;
	} quo_t;

endpackage

@@ hw/rtl/rkd_in_if.sv @@
// ----------------------------------------------------------------------------
// rkd_in_if
// Input channel: one raw RK word per transaction.
// ----------------------------------------------------------------------------
interface rkd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] rk_word;

	modport source (output valid, output rk_word, input ready);
	modport sink   (input valid, input rk_word, output ready);
endinterface

@@ hw/rtl/rkd_out_if.sv @@
// ----------------------------------------------------------------------------
// rkd_out_if
// Output channel: decoded double and form flags per transaction.
// ----------------------------------------------------------------------------
interface rkd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic        was_integer;
	logic        was_scaled;

	modport source (output valid, output value_bits, output was_integer,
		output was_scaled, input ready);
	modport sink   (input valid, input value_bits, input was_integer,
		input was_scaled, output ready);
endinterface

@@ hw/rtl/rkd_unpack.sv @@
// ----------------------------------------------------------------------------
// rkd_unpack
// Stage 1: splits the RK word, normalises the significand, handles the
// cases that need no division.
// ----------------------------------------------------------------------------
module rkd_unpack (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   rk_word,
	output rkd_pkg::unp_t u_s1
);
	logic [31:0]        hi;
	logic               is_int;
	logic               scl;
	logic [29:0]        mag;
	logic [10:0]        expf;
	logic [29:0]        s;
	logic signed [11:0] e0;
	logic               sign;
	logic [4:0]         msb;
	logic [4:0]         shamt;
	logic               zero;
	logic               nan;
	logic               inf;
	rkd_pkg::unp_t      u;

	always_comb begin
		hi     = {rk_word[31:2], 2'b00};
		is_int = rk_word[1];
		scl    = rk_word[0];
		expf   = hi[30:20];
		mag    = rk_word[31] ? 30'(-rk_word[31:2]) : rk_word[31:2];
		if (is_int) begin
			sign = rk_word[31];
			s    = mag;
			e0   = 12'sd0;
		end else if (expf == 11'd0) begin
			sign = hi[31];
			s    = {10'd0, hi[19:0]};
			e0   = rkd_pkg::SUB_E;
		end else begin
			sign = hi[31];
			s    = {9'd0, 1'b1, hi[19:0]};
			e0   = $signed({1'b0, expf}) - rkd_pkg::NORM_EOFS;
		end

		msb = 5'd0;
		for (int i = 0; i < 30; i++) begin
			if (s[i])
				msb = 5'(i);
		end
		shamt = 5'd29 - msb;
		zero  = (s == 30'd0);
		nan   = !is_int && (expf == rkd_pkg::EXP_ALL1) && (hi[19:0] != 20'd0);
		inf   = !is_int && (expf == rkd_pkg::EXP_ALL1) && (hi[19:0] == 20'd0);

		u.sign        = sign;
		u.n           = s << shamt;
		u.e           = e0 - $signed({7'd0, shamt});
		u.was_integer = is_int;
		u.was_scaled  = scl;
		u.direct      = 1'b1;
		u.direct_bits = {hi, 32'd0};
		if (!scl) begin
			if (is_int) begin
				if (zero)
					u.direct_bits = 64'd0;
				else
					u.direct_bits = {sign, rkd_pkg::INT_EBASE - {6'd0, shamt},
						u.n[28:0], 23'd0};
			end
		end else if (nan) begin
			// quiet bit is mantissa bit 51, i.e. bit 19 of the high word
			u.direct_bits = {hi | 32'h0008_0000, 32'd0};
		end else if (inf) begin
			u.direct_bits = {hi, 32'd0};
		end else if (zero) begin
			u.direct_bits = {sign, 63'd0};
		end else begin
			u.direct = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			u_s1 <= u;
	end
endmodule

@@ hw/rtl/rkd_div25.sv @@
// ----------------------------------------------------------------------------
// rkd_div25
// Stages 2-3: quotient and remainder of the significand by 25 through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module rkd_div25 (
	input  logic          clk,
	input  logic          en2,
	input  logic          en3,
	input  rkd_pkg::unp_t u_s1,
	output rkd_pkg::quo_t q_s3
);
	logic [60:0]   prod;
	logic [25:0]   q0_s2;
	rkd_pkg::unp_t u_s2;
	logic [29:0]   rem;

	assign prod = 61'(u_s1.n) * 61'(rkd_pkg::RECIP25);

	always_ff @(posedge clk) begin
		if (en2) begin
			q0_s2 <= prod[60:rkd_pkg::RECIP_SH];
			u_s2  <= u_s1;
		end
	end

	assign rem = u_s2.n - 30'(q0_s2 * 30'(rkd_pkg::DIV25));

	always_ff @(posedge clk) begin
		if (en3) begin
			q_s3.sign        <= u_s2.sign;
			q_s3.q0          <= q0_s2;
			q_s3.r           <= rem[4:0];
			q_s3.e           <= u_s2.e;
			q_s3.direct      <= u_s2.direct;
			q_s3.direct_bits <= u_s2.direct_bits;
			q_s3.was_integer <= u_s2.was_integer;
			q_s3.was_scaled  <= u_s2.was_scaled;
		end
	end
endmodule

@@ hw/rtl/rkd_round.sv @@
// ----------------------------------------------------------------------------
// rkd_round
// Stages 4-5: aligns the quotient to the result exponent (with subnormal
// denormalisation), then rounds to nearest even and packs the double.
// ----------------------------------------------------------------------------
module rkd_round (
	input  logic          clk,
	input  logic          en4,
	input  logic          en5,
	input  rkd_pkg::quo_t q_s3,
	output logic [63:0]   value_bits,
	output logic          was_integer,
	output logic          was_scaled
);
	logic [57:0]        qfull;
	logic signed [12:0] be;
	logic               sub;
	logic signed [12:0] sh13;
	logic [5:0]         sh;
	logic [97:0]        wide;

	logic               sign_s4;
	logic [10:0]        exp_s4;
	logic [51:0]        man_s4;
	logic               grd_s4;
	logic               stk_s4;
	logic               direct_s4;
	logic [63:0]        dbits_s4;
	logic               int_s4;
	logic               scl_s4;
	logic [62:0]        sum;

	// value = qfull * 2^(e - 34), leading one at bit 57 or 56
	always_comb begin
		qfull = {q_s3.q0, rkd_pkg::FRAC_TAB[q_s3.r]};
		be    = 13'(q_s3.e) + (q_s3.q0[25] ? 13'sd1046 : 13'sd1045);
		sub   = (be < 13'sd1);
		sh13  = (q_s3.q0[25] ? 13'sd5 : 13'sd4) + (sub ? (13'sd1 - be) : 13'sd0);
		sh    = (sh13 > 13'sd40) ? 6'd40 : sh13[5:0];
		wide  = {qfull, 40'd0} >> sh;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sign_s4   <= q_s3.sign;
			exp_s4    <= sub ? 11'd0 : be[10:0];
			man_s4    <= wide[91:40];
			grd_s4    <= wide[39];
			stk_s4    <= (|wide[38:0]) || (q_s3.r != 5'd0);
			direct_s4 <= q_s3.direct;
			dbits_s4  <= q_s3.direct_bits;
			int_s4    <= q_s3.was_integer;
			scl_s4    <= q_s3.was_scaled;
		end
	end

	// carry out of the mantissa moves into the exponent field
	assign sum = {exp_s4, man_s4} + 63'(grd_s4 & (stk_s4 | man_s4[0]));

	always_ff @(posedge clk) begin
		if (en5) begin
			value_bits  <= direct_s4 ? dbits_s4 : {sign_s4, sum};
			was_integer <= int_s4;
			was_scaled  <= scl_s4;
		end
	end
endmodule

@@ hw/rtl/rk_number_to_double_core.sv @@
// ----------------------------------------------------------------------------
// rk_number_to_double_core
// RK cell word to IEEE-754 double decoder, five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one RK word per clock and returns one double bit pattern per cycle
// while the output is not stalled. Integer-form words are sign-extended
// and converted exactly; words with bit 0 set are divided by 100 with
// round-to-nearest-even, subnormals included. The division runs as a
// reciprocal multiply by 1/25 (stage 2), a remainder fix-up (stage 3), an
// alignment shift (stage 4) and rounding (stage 5). Each stage moves on when
// the one after it is empty or moving, so output back-pressure stalls the
// pipe without losing or repeating a transaction. Scaled NaNs come out quiet.
// ----------------------------------------------------------------------------
module rk_number_to_double_core (
	input  logic      clk,
	input  logic      arst_n,
	rkd_in_if.sink    rk_in,
	rkd_out_if.source rk_out
);
	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic          en1, en2, en3, en4, en5;
	rkd_pkg::unp_t u_s1;
	rkd_pkg::quo_t q_s3;

	assign en5 = !vld_s5 || rk_out.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign rk_in.ready  = en1;
	assign rk_out.valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= rk_in.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	rkd_unpack u_unpack (
		.clk     (clk),
		.en      (en1),
		.rk_word (rk_in.rk_word),
		.u_s1    (u_s1)
	);

	rkd_div25 u_div25 (
		.clk  (clk),
		.en2  (en2),
		.en3  (en3),
		.u_s1 (u_s1),
		.q_s3 (q_s3)
	);

	rkd_round u_round (
		.clk         (clk),
		.en4         (en4),
		.en5         (en5),
		.q_s3        (q_s3),
		.value_bits  (rk_out.value_bits),
		.was_integer (rk_out.was_integer),
		.was_scaled  (rk_out.was_scaled)
	);
endmodule
